### design/lifnu_pkg.sv
// ----------------------------------------------------------------------------
// LIF neuron update: shared package
// Field widths, register map, reset values and the types that travel between
// the configuration block, the state memory and the update pipeline.
// ----------------------------------------------------------------------------
package lifnu_pkg;

	// Item field widths
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned DECAY_W  = 17;
	localparam int unsigned REFRAC_W = 8;
	localparam int unsigned SLOT_W   = 4;

	// Stream payload widths, padded to whole bytes
	localparam int unsigned S_TDATA_W = 112;
	localparam int unsigned M_TDATA_W = 104;

	// Store depth is bounded by the index field
	localparam int unsigned STORE_DEPTH_MAX = 2 ** INDEX_W;

	// Parameter defaults
	localparam int unsigned NEURONS_DEF      = 1024;
	localparam int unsigned MAX_DELAY_DEF    = 15;
	localparam int unsigned REFRAC_STEPS_DEF = 2;
	localparam logic [DATA_W-1:0] BASE_INDEX_DEF = '0;

	// Configuration port
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	typedef enum logic [2:0] {
		REG_MEMBRANE_DECAY = 3'd0,
		REG_REST_TERM      = 3'd1,
		REG_EXC_GAIN       = 3'd2,
		REG_INH_GAIN       = 3'd3,
		REG_EXC_DECAY      = 3'd4,
		REG_INH_DECAY      = 3'd5,
		REG_THRESHOLD      = 3'd6,
		REG_RESET_VOLTAGE  = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic [DECAY_W-1:0] MEMBRANE_DECAY_RST = 17'd62259;
	localparam logic [DATA_W-1:0]  REST_TERM_RST      = 32'd0;
	localparam logic [DATA_W-1:0]  EXC_GAIN_RST       = 32'd65536;
	localparam logic [DATA_W-1:0]  INH_GAIN_RST       = 32'd65536;
	localparam logic [DECAY_W-1:0] EXC_DECAY_RST      = 17'd52429;
	localparam logic [DECAY_W-1:0] INH_DECAY_RST      = 17'd52429;
	localparam logic [DATA_W-1:0]  THRESHOLD_RST      = 32'd983040;
	localparam logic [DATA_W-1:0]  RESET_VOLTAGE_RST  = 32'd0;

	typedef struct packed {
		logic        [DECAY_W-1:0] membrane_decay;
		logic signed [DATA_W-1:0]  rest_term;
		logic signed [DATA_W-1:0]  exc_gain;
		logic signed [DATA_W-1:0]  inh_gain;
		logic        [DECAY_W-1:0] exc_decay;
		logic        [DECAY_W-1:0] inh_decay;
		logic signed [DATA_W-1:0]  threshold;
		logic signed [DATA_W-1:0]  reset_voltage;
	} cfg_t;

	// One memory word holds the whole state of a neuron
	typedef struct packed {
		logic signed [DATA_W-1:0]   membrane;
		logic signed [DATA_W-1:0]   exc_cur;
		logic signed [DATA_W-1:0]   inh_cur;
		logic        [REFRAC_W-1:0] refrac;
		logic        [DATA_W-1:0]   count;
	} neuron_state_t;

	typedef struct packed {
		logic               en;
		logic [INDEX_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic               en;
		logic [INDEX_W-1:0] addr;
		neuron_state_t      data;
	} mem_wr_t;

endpackage

### design/lifnu_cfg_regs.sv
// ----------------------------------------------------------------------------
// LIF neuron update: configuration registers
// APB-style register file holding the shared neuron and synapse constants.
// ----------------------------------------------------------------------------
module lifnu_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lifnu_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [lifnu_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [lifnu_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready,
	output lifnu_pkg::cfg_t                      cfg
);

	lifnu_pkg::cfg_t      cfg_q;
	lifnu_pkg::reg_idx_t  reg_sel;
	logic                 wr_en;

	assign reg_sel = lifnu_pkg::reg_idx_t'(paddr[lifnu_pkg::APB_ADDR_W-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.membrane_decay <= lifnu_pkg::MEMBRANE_DECAY_RST;
			cfg_q.rest_term      <= lifnu_pkg::REST_TERM_RST;
			cfg_q.exc_gain       <= lifnu_pkg::EXC_GAIN_RST;
			cfg_q.inh_gain       <= lifnu_pkg::INH_GAIN_RST;
			cfg_q.exc_decay      <= lifnu_pkg::EXC_DECAY_RST;
			cfg_q.inh_decay      <= lifnu_pkg::INH_DECAY_RST;
			cfg_q.threshold      <= lifnu_pkg::THRESHOLD_RST;
			cfg_q.reset_voltage  <= lifnu_pkg::RESET_VOLTAGE_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				lifnu_pkg::REG_MEMBRANE_DECAY: begin
					cfg_q.membrane_decay <= pwdata[lifnu_pkg::DECAY_W-1:0];
				end
				lifnu_pkg::REG_REST_TERM:     cfg_q.rest_term     <= pwdata;
				lifnu_pkg::REG_EXC_GAIN:      cfg_q.exc_gain      <= pwdata;
				lifnu_pkg::REG_INH_GAIN:      cfg_q.inh_gain      <= pwdata;
				lifnu_pkg::REG_EXC_DECAY: begin
					cfg_q.exc_decay <= pwdata[lifnu_pkg::DECAY_W-1:0];
				end
				lifnu_pkg::REG_INH_DECAY: begin
					cfg_q.inh_decay <= pwdata[lifnu_pkg::DECAY_W-1:0];
				end
				lifnu_pkg::REG_THRESHOLD:     cfg_q.threshold     <= pwdata;
				lifnu_pkg::REG_RESET_VOLTAGE: cfg_q.reset_voltage <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			lifnu_pkg::REG_MEMBRANE_DECAY: prdata = 32'(cfg_q.membrane_decay);
			lifnu_pkg::REG_REST_TERM:      prdata = cfg_q.rest_term;
			lifnu_pkg::REG_EXC_GAIN:       prdata = cfg_q.exc_gain;
			lifnu_pkg::REG_INH_GAIN:       prdata = cfg_q.inh_gain;
			lifnu_pkg::REG_EXC_DECAY:      prdata = 32'(cfg_q.exc_decay);
			lifnu_pkg::REG_INH_DECAY:      prdata = 32'(cfg_q.inh_decay);
			lifnu_pkg::REG_THRESHOLD:      prdata = cfg_q.threshold;
			lifnu_pkg::REG_RESET_VOLTAGE:  prdata = cfg_q.reset_voltage;
		endcase
	end

endmodule

### design/lifnu_state_mem.sv
// ----------------------------------------------------------------------------
// LIF neuron update: neuron state memory
// One synchronous memory word per neuron, one read and one write port, with a
// clearing pass after reset that zeroes every word.
// ----------------------------------------------------------------------------
module lifnu_state_mem #(
	parameter int unsigned DEPTH = lifnu_pkg::STORE_DEPTH_MAX
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lifnu_pkg::mem_rd_t        rd_req,
	output lifnu_pkg::neuron_state_t  rd_data,
	input  lifnu_pkg::mem_wr_t        wr_req,
	output logic                      busy
);

	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	lifnu_pkg::neuron_state_t  mem [DEPTH];
	lifnu_pkg::neuron_state_t  rd_data_q;
	logic [ADDR_W-1:0]         clr_addr_q;
	logic                      clr_busy_q;

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

	// Clearing pass: one word per cycle from address zero upwards.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_req.en) begin
			mem[wr_req.addr[ADDR_W-1:0]] <= wr_req.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd_data_q <= mem[rd_req.addr[ADDR_W-1:0]];
		end
	end

endmodule

### design/lifnu_datapath.sv
// ----------------------------------------------------------------------------
// LIF neuron update: update pipeline
// Three arithmetic stages and an output register around the state memory:
// multiply, sum and saturate, then fire decision and write-back.
// ----------------------------------------------------------------------------
module lifnu_datapath #(
	parameter int unsigned          NEURONS      = lifnu_pkg::NEURONS_DEF,
	parameter int unsigned          MAX_DELAY    = lifnu_pkg::MAX_DELAY_DEF,
	parameter int unsigned          REFRAC_STEPS = lifnu_pkg::REFRAC_STEPS_DEF,
	parameter logic [31:0]          BASE_INDEX   = lifnu_pkg::BASE_INDEX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lifnu_pkg::cfg_t                     cfg,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lifnu_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lifnu_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                                m_tuser,
	input  logic                                mem_busy,
	output lifnu_pkg::mem_rd_t                  rd_req,
	input  lifnu_pkg::neuron_state_t            rd_data,
	output lifnu_pkg::mem_wr_t                  wr_req
);

	localparam int unsigned IW = lifnu_pkg::INDEX_W;
	localparam int unsigned DW = lifnu_pkg::DATA_W;
	localparam int unsigned RW = lifnu_pkg::REFRAC_W;
	localparam int unsigned SUM_W  = 51;
	localparam int unsigned DPROD_W = 50;
	localparam int unsigned GPROD_W = 64;
	localparam int unsigned REM_W  = 10;
	localparam int unsigned SLOT_DIV = MAX_DELAY + 1;
	// floor(2^32 / divisor): the quotient estimate is low by at most one
	localparam logic [32:0] SLOT_RECIP = 33'(64'h1_0000_0000 / 64'(SLOT_DIV));
	localparam logic [RW-1:0] REFRAC_LOAD = RW'(REFRAC_STEPS - 1);

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic fits;
		fits = (&v[SUM_W-1:31]) || !(|v[SUM_W-1:31]);
		if (fits) begin
			return v[31:0];
		end
		return v[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	// Input fields
	logic        [IW-1:0] in_idx;
	logic signed [DW-1:0] in_exc;
	logic signed [DW-1:0] in_inh;
	logic        [DW-1:0] in_time;

	assign in_idx  = s_tdata[9:0];
	assign in_exc  = s_tdata[41:10];
	assign in_inh  = s_tdata[73:42];
	assign in_time = s_tdata[105:74];

	// Stage valids and flow control
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic out_free, adv3, s3_free, adv2, s2_free, adv1, s1_free;
	logic hazard, accept;

	// Stage 1 payload
	logic        [IW-1:0] idx_s1;
	logic                 in_range_s1;
	logic signed [DW-1:0] exc_in_s1, inh_in_s1;
	logic        [DW-1:0] t_s1;
	logic        [63:0]   slot_prod;

	// Stage 2 payload
	logic        [IW-1:0]      idx_s2;
	logic                      in_range_s2;
	logic signed [DW-1:0]      exc_in_s2, inh_in_s2;
	logic        [DW-1:0]      t_s2, q_s2;
	lifnu_pkg::neuron_state_t  old_s2;
	logic signed [DPROD_W-1:0] pv_s2, pe_dec_s2, pi_dec_s2;
	logic signed [GPROD_W-1:0] pe_gain_s2, pi_gain_s2;
	logic signed [SUM_W-1:0]   term_v, term_e, term_i, term_rest, v_sum;
	logic signed [SUM_W-1:0]   e_dec_wide, i_dec_wide;

	// Stage 3 payload
	logic        [IW-1:0]      idx_s3;
	logic                      in_range_s3;
	logic signed [DW-1:0]      exc_in_s3, inh_in_s3;
	lifnu_pkg::neuron_state_t  old_s3;
	logic signed [DW-1:0]      v_new_s3, ne_dec_s3, ni_dec_s3;
	logic        [REM_W-1:0]   r_s3, r_fix;
	logic                      live, fire;
	logic signed [DW-1:0]      exc_sum, inh_sum;
	lifnu_pkg::neuron_state_t  new_state;

	// Output register
	logic [lifnu_pkg::M_TDATA_W-1:0] out_tdata_q;
	logic                            out_fired_q;
	logic [DW-1:0]                   out_membrane, out_count, out_global;

	assign out_free = !out_valid_q || m_tready;
	assign adv3     = v_s3 && out_free;
	assign s3_free  = !v_s3 || adv3;
	assign adv2     = v_s2 && s3_free;
	assign s2_free  = !v_s2 || adv2;
	assign adv1     = v_s1 && s2_free;
	assign s1_free  = !v_s1 || adv1;

	// A neuron still in flight has not been written back yet.
	assign hazard = (v_s1 && (idx_s1 == in_idx)) || (v_s2 && (idx_s2 == in_idx)) ||
	                (v_s3 && (idx_s3 == in_idx));
	assign s_tready = s1_free && !mem_busy && !hazard;
	assign accept   = s_tvalid && s_tready;

	assign rd_req.en   = accept;
	assign rd_req.addr = in_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= accept;
			end
			if (s2_free) begin
				v_s2 <= adv1;
			end
			if (s3_free) begin
				v_s3 <= adv2;
			end
			if (out_free) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// ---- Stage 1: memory word arrives, all products formed ----
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1      <= in_idx;
			in_range_s1 <= (32'(in_idx) < 32'(NEURONS));
			exc_in_s1   <= in_exc;
			inh_in_s1   <= in_inh;
			t_s1        <= in_time;
		end
	end

	assign slot_prod = 64'(t_s1) * 64'(SLOT_RECIP);

	always_ff @(posedge clk) begin
		if (adv1) begin
			idx_s2      <= idx_s1;
			in_range_s2 <= in_range_s1;
			exc_in_s2   <= exc_in_s1;
			inh_in_s2   <= inh_in_s1;
			t_s2        <= t_s1;
			q_s2        <= slot_prod[63:32];
			old_s2      <= rd_data;
			pv_s2       <= $signed({1'b0, cfg.membrane_decay}) * rd_data.membrane;
			pe_gain_s2  <= cfg.exc_gain * rd_data.exc_cur;
			pi_gain_s2  <= cfg.inh_gain * rd_data.inh_cur;
			pe_dec_s2   <= $signed({1'b0, cfg.exc_decay}) * rd_data.exc_cur;
			pi_dec_s2   <= $signed({1'b0, cfg.inh_decay}) * rd_data.inh_cur;
		end
	end

	// ---- Stage 2: scale by 2^-16 (floor), sum and saturate ----
	assign term_v     = SUM_W'(pv_s2 >>> 16);
	assign term_e     = SUM_W'(pe_gain_s2 >>> 16);
	assign term_i     = SUM_W'(pi_gain_s2 >>> 16);
	assign term_rest  = SUM_W'(cfg.rest_term);
	assign v_sum      = term_v + term_rest + term_e + term_i;
	assign e_dec_wide = SUM_W'(pe_dec_s2 >>> 16);
	assign i_dec_wide = SUM_W'(pi_dec_s2 >>> 16);

	always_ff @(posedge clk) begin
		if (adv2) begin
			idx_s3      <= idx_s2;
			in_range_s3 <= in_range_s2;
			exc_in_s3   <= exc_in_s2;
			inh_in_s3   <= inh_in_s2;
			old_s3      <= old_s2;
			v_new_s3    <= sat32(v_sum);
			ne_dec_s3   <= sat32(e_dec_wide);
			ni_dec_s3   <= sat32(i_dec_wide);
			r_s3        <= REM_W'(t_s2 - 32'(q_s2 * 32'(SLOT_DIV)));
		end
	end

	// ---- Stage 3: fire decision, input integration, write-back ----
	assign live    = in_range_s3 && (old_s3.refrac == '0);
	assign fire    = live && (v_new_s3 >= cfg.threshold);
	assign exc_sum = sat32(SUM_W'(ne_dec_s3) + SUM_W'(exc_in_s3));
	assign inh_sum = sat32(SUM_W'(ni_dec_s3) + SUM_W'(inh_in_s3));
	assign r_fix   = (r_s3 >= REM_W'(SLOT_DIV)) ? r_s3 - REM_W'(SLOT_DIV) : r_s3;

	always_comb begin
		new_state = old_s3;
		if (old_s3.refrac != '0) begin
			new_state.refrac = old_s3.refrac - 1'b1;
		end else if (fire) begin
			new_state.membrane = cfg.reset_voltage;
			new_state.exc_cur  = ne_dec_s3;
			new_state.inh_cur  = ni_dec_s3;
			new_state.refrac   = REFRAC_LOAD;
			if (old_s3.count != '1) begin
				new_state.count = old_s3.count + 1'b1;
			end
		end else begin
			new_state.membrane = v_new_s3;
			new_state.exc_cur  = exc_sum;
			new_state.inh_cur  = inh_sum;
		end
	end

	assign wr_req.en   = adv3 && in_range_s3;
	assign wr_req.addr = idx_s3;
	assign wr_req.data = new_state;

	// Out-of-range neurons report zero voltage and count.
	assign out_membrane = in_range_s3 ? new_state.membrane : '0;
	assign out_count    = in_range_s3 ? new_state.count : '0;
	assign out_global   = BASE_INDEX + 32'(idx_s3);

	always_ff @(posedge clk) begin
		if (adv3) begin
			out_tdata_q <= {4'd0, out_count, out_membrane,
			                r_fix[lifnu_pkg::SLOT_W-1:0], out_global};
			out_fired_q <= fire;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_tdata_q;
	assign m_tuser  = out_fired_q;

endmodule

### design/lif_neuron_update.sv
// ----------------------------------------------------------------------------
// LIF neuron update: top level
// Leaky integrate-and-fire neuron with exponential synaptic currents, state
// held in one on-chip memory and updated one neuron per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage
//  Each request on the slave stream names a neuron, brings its summed
//  excitatory and inhibitory input and the tick number. For every request one
//  result leaves on the master stream, in request order: global index, tick
//  slot, new membrane voltage, spike count, and the spike flag on m_tuser.
//  The shared constants are set over the APB port while no request is in
//  flight; pready is tied high and every register reads back.
//  An accepted request passes every pipeline stage and the output register
//  before its result is offered. Throughput is one request per cycle unless
//  a stall, the interlock or the clearing pass holds it: the state memory is
//  read when a request is accepted and written back as it leaves the last
//  stage, so a request for a neuron still in the pipeline waits until its
//  predecessor has been written back. After reset the memory clears one word
//  per cycle, min(NEURONS, 1024) words (1024 by default); s_tready stays low.
//  When the receiver stalls the result holds in the output register and the
//  pipeline keeps filling until every stage is occupied, then s_tready drops.
// ----------------------------------------------------------------------------
module lif_neuron_update #(
	parameter int unsigned NEURONS      = lifnu_pkg::NEURONS_DEF,
	parameter int unsigned MAX_DELAY    = lifnu_pkg::MAX_DELAY_DEF,
	parameter int unsigned REFRAC_STEPS = lifnu_pkg::REFRAC_STEPS_DEF,
	parameter logic [31:0] BASE_INDEX   = lifnu_pkg::BASE_INDEX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Slave stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// neuron_index[9:0], exc_input[41:10], inh_input[73:42],
	// time_step[105:74], zero padding[111:106]
	input  logic [lifnu_pkg::S_TDATA_W-1:0]     s_tdata,
	// Master stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// global_index[31:0], delay_slot[35:32], membrane[67:36],
	// spike_total[99:68], zero padding[103:100]
	output logic [lifnu_pkg::M_TDATA_W-1:0]     m_tdata,
	// fired[0]
	output logic                                m_tuser,
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lifnu_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [lifnu_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [lifnu_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready
);

	// Only indices below NEURONS own a memory word, and the index field
	// caps the depth at 1024.
	localparam int unsigned STORE_DEPTH = (NEURONS < lifnu_pkg::STORE_DEPTH_MAX) ?
	                                      NEURONS : lifnu_pkg::STORE_DEPTH_MAX;

	lifnu_pkg::cfg_t           cfg;
	lifnu_pkg::mem_rd_t        rd_req;
	lifnu_pkg::mem_wr_t        wr_req;
	lifnu_pkg::neuron_state_t  rd_data;
	logic                      mem_busy;

	// Shared neuron and synapse constants
	lifnu_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Per-neuron state: voltage, both currents, refractory count, spike count
	lifnu_state_mem #(
		.DEPTH (STORE_DEPTH)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_req  (rd_req),
		.rd_data (rd_data),
		.wr_req  (wr_req),
		.busy    (mem_busy)
	);

	// Read-modify-write pipeline with the same-neuron interlock
	lifnu_datapath #(
		.NEURONS      (NEURONS),
		.MAX_DELAY    (MAX_DELAY),
		.REFRAC_STEPS (REFRAC_STEPS),
		.BASE_INDEX   (BASE_INDEX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.mem_busy (mem_busy),
		.rd_req   (rd_req),
		.rd_data  (rd_data),
		.wr_req   (wr_req)
	);

endmodule

### design/lifnu_checker.sv
// ----------------------------------------------------------------------------
// LIF neuron update: port checker
// Concurrent checks on the stream ports, bound to the top level.
// ----------------------------------------------------------------------------
module lifnu_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [lifnu_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [lifnu_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                                m_tuser
);

	localparam int unsigned PIPE_SLOTS = 4;

	logic       s_acc, m_acc;
	logic [2:0] in_flight_q;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
		end else begin
			in_flight_q <= in_flight_q + 3'(s_acc) - 3'(m_acc);
		end
	end

	// A stalled result is held unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The same neuron is not accepted on consecutive cycles.
	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !(s_acc && (s_tdata[9:0] == $past(s_tdata[9:0]))))
		else $error("same neuron accepted on consecutive cycles");

	// A spike always leaves a non-zero spike count.
	a_fired_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[99:68] != '0)
		else $error("spike reported with zero spike count");

	// Never more requests in flight than pipeline slots.
	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= 3'(PIPE_SLOTS))
		else $error("more requests in flight than the pipeline holds");

	// No result without an outstanding request.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> in_flight_q != '0)
		else $error("result offered without an outstanding request");

endmodule

bind lif_neuron_update lifnu_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### test/tb_lif_neuron_update.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIF neuron update: stream testbench
// Requests go in on the slave stream from a queue and results are checked on
// the master stream. Each result is compared against a behavioural model of
// the neuron population that is kept inside this bench. The shared constants
// are changed over APB between phases while the block is idle. Stream sides
// idle in random bursts, except in the last phase and the receiver in one draw.
// ----------------------------------------------------------------------------
module tb_lif_neuron_update;

	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned SW          = lifnu_pkg::SLOT_W;
	localparam int unsigned SLOT_MOD    = lifnu_pkg::MAX_DELAY_DEF + 1;
	localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN       = 32'h8000_0000;
	localparam logic [31:0] Q_ONE       = 32'h0001_0000;

	// What one result on the master stream should carry.
	typedef struct packed {
		logic [31:0]        global_index;
		logic               fired;
		logic [SW-1:0]      slot;
		logic signed [31:0] membrane;
		logic [31:0]        spike_total;
	} neuron_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	// neuron_index[9:0], exc_input[41:10], inh_input[73:42],
	// time_step[105:74], zero padding[111:106]
	logic [lifnu_pkg::S_TDATA_W-1:0]  s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	// global_index[31:0], delay_slot[35:32], membrane[67:36],
	// spike_total[99:68], zero padding[103:100]
	logic [lifnu_pkg::M_TDATA_W-1:0]  m_tdata;
	// fired[0]
	logic                             m_tuser;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [lifnu_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [lifnu_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [lifnu_pkg::APB_DATA_W-1:0] prdata;
	logic                             pready;

	// Shadow copy of the configuration and of every neuron's state.
	lifnu_pkg::cfg_t    shadow_cfg;
	logic signed [31:0] membrane_mem [lifnu_pkg::STORE_DEPTH_MAX];
	logic signed [31:0] exc_cur_mem [lifnu_pkg::STORE_DEPTH_MAX];
	logic signed [31:0] inh_cur_mem [lifnu_pkg::STORE_DEPTH_MAX];
	logic [7:0]         refrac_mem [lifnu_pkg::STORE_DEPTH_MAX];
	logic [31:0]        spike_mem [lifnu_pkg::STORE_DEPTH_MAX];

	logic [lifnu_pkg::S_TDATA_W-1:0] update_reqs [$];
	neuron_result_t                  neuron_results [$];

	int unsigned reqs_queued = 0;
	int unsigned reqs_taken = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_hold = 0;
	int unsigned recv_hold = 0;
	bit          send_idle_on = 1'b1;
	bit          recv_idle_on = 1'b1;
	bit          req_taken = 1'b0;
	logic [31:0] tick = '0;

	lif_neuron_update u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Behavioural model
	// ------------------------------------------------------------------

	// Q16.16 product, floored: the arithmetic shift rounds toward minus
	// infinity, which is what the fixed-point datapath is meant to do.
	function automatic longint fix_mul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic logic signed [31:0] sat32(longint x);
		if (x > 64'sd2147483647)
			return Q_MAX;
		if (x < -64'sd2147483648)
			return Q_MIN;
		return x[31:0];
	endfunction

	// Applies one request to the shadow state and returns the result that the
	// block must produce for it.
	function automatic neuron_result_t advance_neuron(logic [lifnu_pkg::S_TDATA_W-1:0] req);
		logic [lifnu_pkg::INDEX_W-1:0] idx;
		longint             exc_in, inh_in, ie, ii, v_old, thr, v_sum;
		longint             k_mem, k_exc, k_inh, g_exc, g_inh, rest;
		logic [31:0]        t;
		logic signed [31:0] v, ne, ni;
		neuron_result_t     r;
		idx    = req[9:0];
		exc_in = longint'($signed(req[41:10]));
		inh_in = longint'($signed(req[73:42]));
		t      = req[105:74];
		k_mem  = longint'(shadow_cfg.membrane_decay);
		k_exc  = longint'(shadow_cfg.exc_decay);
		k_inh  = longint'(shadow_cfg.inh_decay);
		g_exc  = longint'(shadow_cfg.exc_gain);
		g_inh  = longint'(shadow_cfg.inh_gain);
		rest   = longint'(shadow_cfg.rest_term);
		thr    = longint'(shadow_cfg.threshold);
		r.global_index = lifnu_pkg::BASE_INDEX_DEF + 32'(idx);
		r.slot  = SW'(t % SLOT_MOD);
		r.fired = 1'b0;
		if (refrac_mem[idx] == 8'd0) begin
			ie    = longint'(exc_cur_mem[idx]);
			ii    = longint'(inh_cur_mem[idx]);
			v_old = longint'(membrane_mem[idx]);
			// The membrane sum is kept at full precision and saturated once.
			v_sum = fix_mul(k_mem, v_old) + rest + fix_mul(g_exc, ie) + fix_mul(g_inh, ii);
			v  = sat32(v_sum);
			ne = sat32(fix_mul(k_exc, ie));
			ni = sat32(fix_mul(k_inh, ii));
			if (longint'(v) >= thr) begin
				// Spike: reset, go refractory and throw this tick's input away.
				r.fired = 1'b1;
				if (spike_mem[idx] != 32'hFFFF_FFFF)
					spike_mem[idx] = spike_mem[idx] + 32'd1;
				refrac_mem[idx] = 8'(lifnu_pkg::REFRAC_STEPS_DEF - 1);
				v = shadow_cfg.reset_voltage;
			end else begin
				ne = sat32(longint'(ne) + exc_in);
				ni = sat32(longint'(ni) + inh_in);
			end
			membrane_mem[idx] = v;
			exc_cur_mem[idx]  = ne;
			inh_cur_mem[idx]  = ni;
		end else begin
			refrac_mem[idx] = refrac_mem[idx] - 8'd1;
		end
		r.membrane    = membrane_mem[idx];
		r.spike_total = spike_mem[idx];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t ERROR %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// Requests are predicted as they are accepted; results are compared with
	// the oldest prediction. The watchdog counts cycles with no transfer on
	// either stream.
	always @(posedge clk) begin
		neuron_result_t want;
		req_taken = arst_n && s_tvalid && s_tready;
		if (req_taken) begin
			neuron_results.push_back(advance_neuron(s_tdata));
			reqs_taken++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (neuron_results.size() == 0) begin
				flag_mismatch("result with no request waiting", m_tdata[31:0], '0);
			end else begin
				want = neuron_results.pop_front();
				if (m_tdata[31:0] !== want.global_index)
					flag_mismatch("global_index", m_tdata[31:0], want.global_index);
				if (m_tuser !== want.fired)
					flag_mismatch("fired", 32'(m_tuser), 32'(want.fired));
				if (m_tdata[35:32] !== want.slot)
					flag_mismatch("delay_slot", 32'(m_tdata[35:32]), 32'(want.slot));
				if (m_tdata[67:36] !== want.membrane)
					flag_mismatch("membrane", m_tdata[67:36], want.membrane);
				if (m_tdata[99:68] !== want.spike_total)
					flag_mismatch("spike_total", m_tdata[99:68], want.spike_total);
			end
		end
		if (arst_n) begin
			if (req_taken || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ERROR watchdog: no transfer for %0d cycles", $realtime,
					QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stream drivers
	// ------------------------------------------------------------------

	// Sender: a request stays offered until it is taken. Idle bursts only
	// start between requests.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (send_hold != 0) begin
				send_hold--;
				s_tvalid <= 1'b0;
			end else if (send_idle_on && $urandom_range(0, 11) == 0) begin
				send_hold = $urandom_range(0, 6);
				s_tvalid <= 1'b0;
			end else if (update_reqs.size() != 0) begin
				s_tdata  <= update_reqs.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: back-pressure in bursts of random length.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (recv_hold != 0) begin
			recv_hold--;
			m_tready <= 1'b0;
		end else if (recv_idle_on && $urandom_range(0, 9) == 0) begin
			recv_hold = $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic push_req(logic [9:0] idx, logic [31:0] exc, logic [31:0] inh,
		logic [31:0] t);
		update_reqs.push_back({6'b0, t, inh, exc, idx});
		reqs_queued++;
	endtask

	// Holds off until every queued request has been taken and answered.
	task automatic drain();
		do
			@(negedge clk);
		while (reqs_taken != reqs_queued || neuron_results.size() != 0);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(lifnu_pkg::reg_idx_t which, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (which)
			lifnu_pkg::REG_MEMBRANE_DECAY: begin
				shadow_cfg.membrane_decay = value[lifnu_pkg::DECAY_W-1:0];
			end
			lifnu_pkg::REG_REST_TERM:      shadow_cfg.rest_term     = value;
			lifnu_pkg::REG_EXC_GAIN:       shadow_cfg.exc_gain      = value;
			lifnu_pkg::REG_INH_GAIN:       shadow_cfg.inh_gain      = value;
			lifnu_pkg::REG_EXC_DECAY: begin
				shadow_cfg.exc_decay = value[lifnu_pkg::DECAY_W-1:0];
			end
			lifnu_pkg::REG_INH_DECAY: begin
				shadow_cfg.inh_decay = value[lifnu_pkg::DECAY_W-1:0];
			end
			lifnu_pkg::REG_THRESHOLD:      shadow_cfg.threshold     = value;
			lifnu_pkg::REG_RESET_VOLTAGE:  shadow_cfg.reset_voltage = value;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_settings(logic [31:0] k_mem, logic [31:0] rest, logic [31:0] g_exc,
		logic [31:0] g_inh, logic [31:0] k_exc, logic [31:0] k_inh, logic [31:0] thr,
		logic [31:0] v_reset);
		write_reg(lifnu_pkg::REG_MEMBRANE_DECAY, k_mem);
		write_reg(lifnu_pkg::REG_REST_TERM, rest);
		write_reg(lifnu_pkg::REG_EXC_GAIN, g_exc);
		write_reg(lifnu_pkg::REG_INH_GAIN, g_inh);
		write_reg(lifnu_pkg::REG_EXC_DECAY, k_exc);
		write_reg(lifnu_pkg::REG_INH_DECAY, k_inh);
		write_reg(lifnu_pkg::REG_THRESHOLD, thr);
		write_reg(lifnu_pkg::REG_RESET_VOLTAGE, v_reset);
	endtask

	// Synaptic input: mostly a plausible drive (positive for excitation,
	// negative for inhibition), now and then a saturating or arbitrary value.
	function automatic logic [31:0] syn_value(bit excite);
		case ($urandom_range(0, 19))
			0: return $urandom;
			1: return Q_MAX;
			2: return Q_MIN;
			3: return 32'hFFFF_FFFF;
			4: return 32'd0;
			default: return excite ? $urandom_range(0, 6 * Q_ONE) : -$urandom_range(0, 4 * Q_ONE);
		endcase
	endfunction

	// A random phase works mainly on a handful of neurons, so that currents
	// build up, neurons fire and go refractory, and the same neuron often
	// comes back while its previous update is still in flight.
	task automatic queue_random(int unsigned count);
		logic [9:0]  group [8];
		logic [9:0]  idx;
		logic [31:0] t;
		foreach (group[g])
			group[g] = 10'($urandom_range(0, lifnu_pkg::STORE_DEPTH_MAX - 1));
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(0, 19) < 17)
				idx = group[$urandom_range(0, 7)];
			else
				idx = 10'($urandom_range(0, lifnu_pkg::STORE_DEPTH_MAX - 1));
			if ($urandom_range(0, 5) == 0)
				tick = tick + 32'd1;
			t = ($urandom_range(0, 9) == 0) ? $urandom : tick;
			push_req(idx, syn_value(1'b1), syn_value(1'b0), t);
		end
	endtask

	initial begin
		shadow_cfg.membrane_decay = lifnu_pkg::MEMBRANE_DECAY_RST;
		shadow_cfg.rest_term      = lifnu_pkg::REST_TERM_RST;
		shadow_cfg.exc_gain       = lifnu_pkg::EXC_GAIN_RST;
		shadow_cfg.inh_gain       = lifnu_pkg::INH_GAIN_RST;
		shadow_cfg.exc_decay      = lifnu_pkg::EXC_DECAY_RST;
		shadow_cfg.inh_decay      = lifnu_pkg::INH_DECAY_RST;
		shadow_cfg.threshold      = lifnu_pkg::THRESHOLD_RST;
		shadow_cfg.reset_voltage  = lifnu_pkg::RESET_VOLTAGE_RST;
		for (int i = 0; i < lifnu_pkg::STORE_DEPTH_MAX; i++) begin
			membrane_mem[i] = '0;
			exc_cur_mem[i]  = '0;
			inh_cur_mem[i]  = '0;
			refrac_mem[i]   = '0;
			spike_mem[i]    = '0;
		end

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset constants: index and time extremes,
		// saturating inputs in both directions, a neuron driven over threshold
		// then refractory then integrating again, a neuron whose membrane
		// saturates high, one pinned at the negative rail, alternating bit
		// patterns, and back-to-back requests for one neuron.
		push_req(10'd0, 32'd0, 32'd0, 32'd0);
		push_req(10'd1023, Q_MAX, Q_MIN, 32'hFFFF_FFFF);
		push_req(10'd1023, Q_MIN, Q_MAX, 32'd16);
		push_req(10'd5, 16 * Q_ONE, 32'd0, 32'd1);
		push_req(10'd5, 32'd0, 32'd0, 32'd2);
		push_req(10'd5, 32'd0, 32'd0, 32'd3);
		push_req(10'd5, 32'd0, 32'd0, 32'd4);
		push_req(10'd7, Q_MAX, 32'd0, 32'd5);
		push_req(10'd7, Q_MAX, 32'd0, 32'd6);
		push_req(10'd7, Q_MAX, 32'd0, 32'd7);
		push_req(10'd9, 32'd0, Q_MIN, 32'd8);
		push_req(10'd9, 32'd0, Q_MIN, 32'd9);
		push_req(10'd9, 32'd0, 32'd0, 32'd10);
		push_req(10'd341, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5A5A_5A5A);
		push_req(10'd682, 32'hAAAA_AAAA, 32'h5555_5555, 32'hA5A5_A5A5);
		push_req(10'd5, 32'hFFFF_FFFF, 32'd1, 32'd31);
		push_req(10'd5, 20 * Q_ONE, 32'd0, 32'd32);
		drain();

		// Pure integrators: no leak on anything, spike then pull below rest.
		apply_settings(32'd65536, 32'd0, Q_ONE, Q_ONE, 32'd65536, 32'd65536, 10 * Q_ONE,
			-(2 * Q_ONE));
		queue_random(110);
		drain();

		// Rails, one way: fires whenever not refractory, decays at zero and past unity.
		apply_settings(32'd0, Q_MAX, Q_MIN, Q_MAX, 32'd0, 32'h1FFFF, Q_MIN, Q_MAX);
		queue_random(100);
		drain();

		// Rails, the other way: never reaches threshold short of saturation.
		apply_settings(32'h1FFFF, Q_MIN, Q_MAX, Q_MIN, 32'h1FFFF, 32'd0, Q_MAX, Q_MIN);
		queue_random(100);
		drain();

		// Plausible neuron settings, three draws; receiver never stalls in one.
		for (int p = 0; p < 3; p++) begin
			recv_idle_on = (p != 1);
			apply_settings($urandom_range(45000, 65536), $urandom_range(0, 32'h8000),
				$urandom_range(32768, 131072), $urandom_range(16384, 98304),
				$urandom_range(30000, 65536), $urandom_range(30000, 65536),
				$urandom_range(2 * Q_ONE, 24 * Q_ONE), -$urandom_range(0, 3 * Q_ONE));
			queue_random(110);
			drain();
		end
		recv_idle_on = 1'b1;

		// Random values in every register, decay fields with random high bits too.
		apply_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		queue_random(110);
		drain();

		// Back to the reset constants, full rate on both sides.
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		apply_settings(32'(lifnu_pkg::MEMBRANE_DECAY_RST), lifnu_pkg::REST_TERM_RST,
			lifnu_pkg::EXC_GAIN_RST, lifnu_pkg::INH_GAIN_RST,
			32'(lifnu_pkg::EXC_DECAY_RST), 32'(lifnu_pkg::INH_DECAY_RST),
			lifnu_pkg::THRESHOLD_RST, lifnu_pkg::RESET_VOLTAGE_RST);
		queue_random(140);
		drain();

		// Allow for a result still in the pipeline that nothing predicted.
		repeat (12) @(negedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
design/lifnu_pkg.sv
design/lifnu_cfg_regs.sv
design/lifnu_state_mem.sv
design/lifnu_datapath.sv
design/lif_neuron_update.sv
design/lifnu_checker.sv
test/tb_lif_neuron_update.sv
